// ===== design/bba_pkg.sv =====
package bba_pkg;

   // Number of storage blocks that the bitmap covers.
   localparam int BLOCK_COUNT = 4096;

   // Width of a block number on the ports.
   localparam int IDX_W = 12;

   // Only blocks that a 12-bit number can name exist.
   localparam int ADDR_BLOCKS = (BLOCK_COUNT < (1 << IDX_W)) ? BLOCK_COUNT : (1 << IDX_W);

   // Bitmap bytes that hold addressable blocks, and the byte address width.
   localparam int ADDR_BYTES = (ADDR_BLOCKS + 7) / 8;
   localparam int BYTE_AW    = (ADDR_BYTES > 1) ? $clog2(ADDR_BYTES) : 1;
   localparam logic [BYTE_AW-1:0] LAST_BYTE = BYTE_AW'(ADDR_BYTES - 1);

   // Request actions.
   typedef enum logic [1:0] {
      ACT_QUERY = 2'd0,
      ACT_FIND  = 2'd1,
      ACT_USED  = 2'd2,
      ACT_FREE  = 2'd3
   } action_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_SCAN,
      ST_DONE
   } state_type;

   // One result item as it passes from the sequencer to the output register.
   typedef struct packed {
      logic             is_free;
      logic             found;
      logic [IDX_W-1:0] free_index;
   } res_type;

endpackage

// ===== design/bba_ram.sv =====
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bba_engine.sv =====
module bba_engine
   import bba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_action,
   input  logic [IDX_W-1:0] req_block_index,
   output logic             res_valid,
   input  logic             res_ready,
   output res_type          res
);

   state_type          state_ff, state_in;
   action_type         act_ff, act_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [BYTE_AW-1:0] clr_ff, clr_in;
   logic [BYTE_AW-1:0] scan_ff, scan_in;
   res_type            res_ff, res_in;

   logic               wr_en;
   logic [BYTE_AW-1:0] wr_addr;
   logic [7:0]         wr_data;
   logic               rd_en;
   logic [BYTE_AW-1:0] rd_addr;
   logic [7:0]         rd_data;

   logic [IDX_W-1:0]   req_shift;
   logic [IDX_W-1:0]   idx_shift;
   logic               in_range;
   logic [7:0]         scan_mask;
   logic [BYTE_AW+2:0] scan_gidx;
   logic               scan_hit;
   logic [2:0]         scan_bit;

   // The usage bitmap, one byte per eight blocks.
   bba_ram #(
      .WIDTH (8),
      .DEPTH (ADDR_BYTES)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Byte addresses of the incoming and the held block numbers.
   assign req_shift = req_block_index >> 3;
   assign idx_shift = idx_ff >> 3;
   assign in_range  = 32'(idx_ff) < 32'(ADDR_BLOCKS);

   // Bits beyond the addressable range count as used during a scan, and the
   // lowest clear bit of what remains is the candidate.
   always_comb begin
      scan_mask = rd_data;
      scan_bit  = 3'd0;
      scan_gidx = '0;
      for (int b = 7; b >= 0; b--) begin
         scan_gidx = {scan_ff, 3'(b)};
         if (32'(scan_gidx) >= 32'(ADDR_BLOCKS)) begin
            scan_mask[b] = 1'b1;
         end
         if (!scan_mask[b]) begin
            scan_bit = 3'(b);
         end
      end
      scan_hit = (scan_mask != 8'hFF);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      idx_ff  <= idx_in;
      scan_ff <= scan_in;
      res_ff  <= res_in;
   end

   // Sequencer: clearing pass, read-modify-write of one byte, or a byte scan.
   // A write back always lands in a cycle with no read, so no forwarding is
   // needed.
   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      idx_in    = idx_ff;
      clr_in    = clr_ff;
      scan_in   = scan_ff;
      res_in    = res_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = idx_shift[BYTE_AW-1:0];
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = req_shift[BYTE_AW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 8'h00;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_BYTE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in = action_type'(req_action);
               idx_in = req_block_index;
               rd_en  = 1'b1;
               res_in = '0;
               if (action_type'(req_action) == ACT_FIND) begin
                  rd_addr  = '0;
                  scan_in  = '0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            // Query answers from the byte; marks write it back modified.
            if (act_ff == ACT_QUERY) begin
               res_in.is_free = in_range && !rd_data[idx_ff[2:0]];
            end else if (act_ff == ACT_USED) begin
               wr_en   = in_range;
               wr_data = rd_data | (8'h01 << idx_ff[2:0]);
            end else begin
               wr_en   = in_range;
               wr_data = rd_data & ~(8'h01 << idx_ff[2:0]);
            end
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            rd_addr = scan_ff + 1'b1;
            if (scan_hit) begin
               res_in.found      = 1'b1;
               res_in.free_index = IDX_W'({scan_ff, scan_bit});
               state_in          = ST_DONE;
            end else if (scan_ff == LAST_BYTE) begin
               state_in = ST_DONE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign res = res_ff;

`ifndef SYNTHESIS
   // The read and the write port never touch the same byte in one cycle.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en && (wr_addr == rd_addr)))
      else $error("bitmap read and write collide on one byte");

   // A mark leaves every field of its result at zero.
   a_mark_zero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && ((act_ff == ACT_USED) || (act_ff == ACT_FREE)))
      |-> (res_ff == '0))
      else $error("mark result is not all zero");

   // A found block lies inside the addressable range.
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && res_ff.found)
      |-> (32'(res_ff.free_index) < 32'(ADDR_BLOCKS)))
      else $error("found block beyond the addressable range");

   // A found result comes only from a find, and a free answer only from a query.
   a_res_source: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE)
      |-> ((!res_ff.found || (act_ff == ACT_FIND))
           && (!res_ff.is_free || (act_ff == ACT_QUERY))))
      else $error("result field set for the wrong action");
`endif

endmodule

// ===== design/block_bitmap_allocator.sv =====
// Block bitmap allocator: keeps one usage bit per storage block in a 512 x 8
// on-chip memory (a set bit means used) and answers one result item for each
// request item: query, find first free, mark used or mark free. After reset a
// clearing pass writes one byte per cycle, and no item is accepted during it.
// A query or a mark reads its byte from memory, a mark then writes it back,
// and the result then waits. A find reads the bitmap one byte per cycle from
// byte 0 upward through the single read port and stops at the byte holding
// the lowest free block, or after the last byte when the bitmap is full.
// One item is worked on at a time; the next is accepted while the previous
// result waits in the output register.
module block_bitmap_allocator
   import bba_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_action,
   input  logic [IDX_W-1:0] req_block_index,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_is_free,
   output logic             rsp_found,
   output logic [IDX_W-1:0] rsp_free_index
);

   logic    res_valid;
   logic    res_ready;
   res_type res;

   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_ff, rsp_in;

   bba_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_block_index (req_block_index),
      .res_valid       (res_valid),
      .res_ready       (res_ready),
      .res             (res)
   );

   // Output register: takes a finished item whenever it is empty or draining.
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_free    = rsp_ff.is_free;
   assign rsp_found      = rsp_ff.found;
   assign rsp_free_index = rsp_ff.free_index;

endmodule
